// ----- sv/hcgv_pkg.sv -----
`default_nettype none

package hcgv_pkg;

	// default store geometry
	localparam int IMG_WIDTH_DEF  = 64;
	localparam int IMG_HEIGHT_DEF = 64;
	localparam int NUM_RADII_DEF  = 16;

	// item modes
	localparam logic [1:0] MODE_VOTE  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_MIN_RADIUS   = 2'd0;
	localparam logic [1:0] REG_RADIUS_COUNT = 2'd1;
	localparam logic [1:0] REG_IMAGE_COLS   = 2'd2;
	localparam logic [1:0] REG_IMAGE_ROWS   = 2'd3;

	// register reset values
	localparam logic [5:0] MIN_RADIUS_RST   = 6'd5;
	localparam logic [4:0] RADIUS_COUNT_RST = 5'd16;
	localparam logic [6:0] IMAGE_COLS_RST   = 7'd64;
	localparam logic [6:0] IMAGE_ROWS_RST   = 7'd64;

	// datapath widths
	localparam int RAD_W   = 7;   // radius and offset magnitude
	localparam int MAG_W   = 11;  // gradient magnitude
	localparam int SUM_W   = 22;  // gx^2 + gy^2
	localparam int TGT_W   = 18;  // 2*r*m
	localparam int ODD_W   = 8;   // 2k-1
	localparam int ODDSQ_W = 16;
	localparam int LHS_W   = ODDSQ_W + SUM_W;
	localparam int RHS_W   = 2 * TGT_W;
	localparam int DIM_W   = 11;  // image bounds up to 1024
	localparam int CNT_W   = 7;   // radius counter
	localparam int CRD_W   = 9;   // signed centre coordinate
	localparam int VOTE_W  = 16;
	localparam logic [VOTE_W-1:0] VOTE_MAX = '1;

endpackage

`default_nettype wire

// ----- sv/hcgv_ram.sv -----
`default_nettype none

module hcgv_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/hcgv_ratio.sv -----
`default_nettype none

// tests (2k-1)^2 * s <= (2*r*m)^2; s joins at the second stage register
module hcgv_ratio (
	input  wire logic                        clk,
	input  wire logic [hcgv_pkg::RAD_W-1:0] k,
	input  wire logic [hcgv_pkg::RAD_W-1:0] r,
	input  wire logic [hcgv_pkg::MAG_W-1:0] m,
	input  wire logic [hcgv_pkg::SUM_W-1:0] s,
	output      logic                        pass
);

	logic [hcgv_pkg::ODD_W-1:0]   odd;
	logic [hcgv_pkg::ODDSQ_W-1:0] oddsq_s1;
	logic [hcgv_pkg::TGT_W-1:0]   tgt_s1;
	logic [hcgv_pkg::LHS_W-1:0]   lhs_s2;
	logic [hcgv_pkg::RHS_W-1:0]   rhs_s2;

	assign odd = {k, 1'b0} - hcgv_pkg::ODD_W'(1);

	// first stage: square of the odd step and the scaled target
	always_ff @(posedge clk) begin
		oddsq_s1 <= hcgv_pkg::ODDSQ_W'(odd * odd);
		tgt_s1   <= (hcgv_pkg::TGT_W'(r) * hcgv_pkg::TGT_W'(m)) << 1;
	end

	// second stage: both sides of the comparison
	always_ff @(posedge clk) begin
		lhs_s2 <= hcgv_pkg::LHS_W'(oddsq_s1) * hcgv_pkg::LHS_W'(s);
		rhs_s2 <= hcgv_pkg::RHS_W'(tgt_s1) * hcgv_pkg::RHS_W'(tgt_s1);
	end

	assign pass = lhs_s2 <= hcgv_pkg::LHS_W'(rhs_s2);

endmodule

`default_nettype wire

// ----- sv/hough_circle_gradient_voter.sv -----
`default_nettype none

// Gradient-directed Hough circle voting into an on-chip accumulator store.
// Items enter on start while busy is low: mode picks vote, read or clear.
// A vote walks the radii min_radius .. min_radius+count-1; per radius the
// two centres col -/+ dx, row -/+ dy are read, incremented (saturating at
// 65535) and written back through the single store. The offsets come
// from an exact rounding test run in two ratio pipelines: the first
// radius takes a 7-step binary search, each further radius one step,
// as dx and dy grow by at most one per radius; with both gradients
// zero the tests are skipped. A read shows vote_count with result_valid
// for one cycle, in ST_RD_OUT after ST_RD; the receiver cannot stall,
// results are never held. A clear sweeps the store one cell a cycle
// over all NUM_RADII*IMG_HEIGHT*IMG_WIDTH cells, 65536 by default; the
// same sweep runs after reset, with busy high throughout. Registers are
// written over the APB port at byte addresses 0, 4, 8, 12; the user must
// write them only while the block is idle, which the block itself does
// not enforce.
module hough_circle_gradient_voter #(
	parameter int IMG_WIDTH  = hcgv_pkg::IMG_WIDTH_DEF,
	parameter int IMG_HEIGHT = hcgv_pkg::IMG_HEIGHT_DEF,
	parameter int NUM_RADII  = hcgv_pkg::NUM_RADII_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// item port
	input  wire logic               start,
	output      logic               busy,
	input  wire logic [1:0]         mode,
	input  wire logic [5:0]         col,
	input  wire logic [5:0]         row,
	input  wire logic signed [10:0] grad_x,
	input  wire logic signed [10:0] grad_y,
	input  wire logic [3:0]         radius_index,
	// result port
	output      logic               result_valid,
	output      logic [15:0]        vote_count,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output      logic [31:0]        prdata,
	output      logic               pready
);

	localparam int DEPTH  = NUM_RADII * IMG_HEIGHT * IMG_WIDTH;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int RAD_W  = hcgv_pkg::RAD_W;
	localparam int DIM_W  = hcgv_pkg::DIM_W;
	localparam int CNT_W  = hcgv_pkg::CNT_W;
	localparam int CRD_W  = hcgv_pkg::CRD_W;
	localparam int VOTE_W = hcgv_pkg::VOTE_W;

	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_PREP    = 8'b0000_0100,
		ST_TEST    = 8'b0000_1000,
		ST_VOTE_RD = 8'b0001_0000,
		ST_VOTE_WR = 8'b0010_0000,
		ST_RD      = 8'b0100_0000,
		ST_RD_OUT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [5:0] min_radius_q;
	logic [4:0] radius_count_q;
	logic [6:0] image_cols_q;
	logic [6:0] image_rows_q;
	logic       cfg_wr;

	// item registers
	logic [5:0]               col_q;
	logic [5:0]               row_q;
	logic [3:0]               ri_q;
	logic                     neg_x_q;
	logic                     neg_y_q;
	logic                     zero_q;
	logic [hcgv_pkg::MAG_W-1:0] mx_q;
	logic [hcgv_pkg::MAG_W-1:0] my_q;
	logic [hcgv_pkg::SUM_W-1:0] s_q;
	logic [CNT_W-1:0]         count_q;
	logic [DIM_W-1:0]         cols_q;
	logic [DIM_W-1:0]         rows_q;

	// walk state
	logic [CNT_W-1:0]  i_q;
	logic [RAD_W-1:0]  r_q;
	logic [RAD_W-1:0]  nx_q;
	logic [RAD_W-1:0]  ny_q;
	logic [2:0]        bit_q;
	logic              search_q;
	logic [1:0]        phase_q;
	logic              j_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] clr_q;
	logic              rd_ok_q;

	// memory port signals
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [VOTE_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [VOTE_W-1:0] ram_rdata;

	// ratio test signals
	logic [RAD_W-1:0] cand_x;
	logic [RAD_W-1:0] cand_y;
	logic             pass_x;
	logic             pass_y;

	// centre signals
	logic [RAD_W-1:0]        dx_mag;
	logic [RAD_W-1:0]        dy_mag;
	logic signed [CRD_W-1:0] off_x;
	logic signed [CRD_W-1:0] off_y;
	logic signed [CRD_W-1:0] col_s;
	logic signed [CRD_W-1:0] row_s;
	logic signed [CRD_W-1:0] cx;
	logic signed [CRD_W-1:0] cy;
	logic                    in_bounds;
	logic [ADDR_W-1:0]       vote_addr;
	logic [ADDR_W-1:0]       read_addr;
	logic                    rd_ok;

	// abs of the incoming gradients
	logic [hcgv_pkg::MAG_W-1:0] abs_x;
	logic [hcgv_pkg::MAG_W-1:0] abs_y;
	logic [CNT_W-1:0]           count_in;
	logic [DIM_W-1:0]           cols_in;
	logic [DIM_W-1:0]           rows_in;

	assign abs_x = grad_x[10] ? (~grad_x + 11'sd1) : grad_x;
	assign abs_y = grad_y[10] ? (~grad_y + 11'sd1) : grad_y;

	assign count_in = (32'(radius_count_q) < NUM_RADII) ? CNT_W'(radius_count_q)
		: CNT_W'(NUM_RADII);
	assign cols_in = (32'(image_cols_q) < IMG_WIDTH) ? DIM_W'(image_cols_q)
		: DIM_W'(IMG_WIDTH);
	assign rows_in = (32'(image_rows_q) < IMG_HEIGHT) ? DIM_W'(image_rows_q)
		: DIM_W'(IMG_HEIGHT);

	assign busy   = (state_q != ST_IDLE);
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_radius_q   <= hcgv_pkg::MIN_RADIUS_RST;
			radius_count_q <= hcgv_pkg::RADIUS_COUNT_RST;
			image_cols_q   <= hcgv_pkg::IMAGE_COLS_RST;
			image_rows_q   <= hcgv_pkg::IMAGE_ROWS_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				hcgv_pkg::REG_MIN_RADIUS:   min_radius_q   <= pwdata[5:0];
				hcgv_pkg::REG_RADIUS_COUNT: radius_count_q <= pwdata[4:0];
				hcgv_pkg::REG_IMAGE_COLS:   image_cols_q   <= pwdata[6:0];
				hcgv_pkg::REG_IMAGE_ROWS:   image_rows_q   <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (paddr[3:2])
			hcgv_pkg::REG_MIN_RADIUS:   prdata = {26'd0, min_radius_q};
			hcgv_pkg::REG_RADIUS_COUNT: prdata = {27'd0, radius_count_q};
			hcgv_pkg::REG_IMAGE_COLS:   prdata = {25'd0, image_cols_q};
			hcgv_pkg::REG_IMAGE_ROWS:   prdata = {25'd0, image_rows_q};
			default:                    prdata = 32'd0;
		endcase
	end

	// candidate offsets: binary search on the first radius, one step after
	assign cand_x = search_q ? (nx_q | RAD_W'(1 << bit_q)) : (nx_q + RAD_W'(1));
	assign cand_y = search_q ? (ny_q | RAD_W'(1 << bit_q)) : (ny_q + RAD_W'(1));

	hcgv_ratio u_ratio_x (
		.clk  (clk),
		.k    (cand_x),
		.r    (r_q),
		.m    (mx_q),
		.s    (s_q),
		.pass (pass_x)
	);

	hcgv_ratio u_ratio_y (
		.clk  (clk),
		.k    (cand_y),
		.r    (r_q),
		.m    (my_q),
		.s    (s_q),
		.pass (pass_y)
	);

	// signed centre offsets and coordinates
	assign dx_mag = zero_q ? r_q : nx_q;
	assign dy_mag = zero_q ? RAD_W'(0) : ny_q;
	assign off_x  = neg_x_q ? -$signed(CRD_W'(dx_mag)) : $signed(CRD_W'(dx_mag));
	assign off_y  = neg_y_q ? -$signed(CRD_W'(dy_mag)) : $signed(CRD_W'(dy_mag));
	assign col_s  = $signed(CRD_W'(col_q));
	assign row_s  = $signed(CRD_W'(row_q));
	assign cx     = j_q ? (col_s + off_x) : (col_s - off_x);
	assign cy     = j_q ? (row_s + off_y) : (row_s - off_y);

	assign in_bounds = !cx[CRD_W-1] && !cy[CRD_W-1]
		&& (DIM_W'(cx[CRD_W-2:0]) < cols_q) && (DIM_W'(cy[CRD_W-2:0]) < rows_q);

	assign vote_addr = ADDR_W'((ADDR_W'(i_q) * ADDR_W'(IMG_HEIGHT)
		+ ADDR_W'(cy[CRD_W-2:0])) * ADDR_W'(IMG_WIDTH) + ADDR_W'(cx[CRD_W-2:0]));

	assign rd_ok = (32'(radius_index) < NUM_RADII) && (32'(row) < IMG_HEIGHT)
		&& (32'(col) < IMG_WIDTH);
	assign read_addr = ADDR_W'((ADDR_W'(ri_q) * ADDR_W'(IMG_HEIGHT) + ADDR_W'(row_q))
		* ADDR_W'(IMG_WIDTH) + ADDR_W'(col_q));

	// store access
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = (ram_rdata == hcgv_pkg::VOTE_MAX) ? ram_rdata
			: ram_rdata + VOTE_W'(1);
		ram_re    = 1'b0;
		ram_raddr = vote_addr;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_VOTE_RD: ram_re = in_bounds;
			ST_VOTE_WR: ram_we = 1'b1;
			ST_RD: begin
				ram_re    = rd_ok_q;
				ram_raddr = read_addr;
			end
			default: ;
		endcase
	end

	hcgv_ram #(
		.WIDTH (VOTE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result
	assign result_valid = (state_q == ST_RD_OUT);
	assign vote_count   = rd_ok_q ? ram_rdata : '0;

	// item latch, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			col_q   <= col;
			row_q   <= row;
			ri_q    <= radius_index;
			neg_x_q <= grad_x[10];
			neg_y_q <= grad_y[10];
			zero_q  <= (grad_x == 11'sd0) && (grad_y == 11'sd0);
			mx_q    <= abs_x;
			my_q    <= abs_y;
			count_q <= count_in;
			cols_q  <= cols_in;
			rows_q  <= rows_in;
			rd_ok_q <= rd_ok;
		end
		if (state_q == ST_PREP) begin
			s_q <= hcgv_pkg::SUM_W'(mx_q * mx_q) + hcgv_pkg::SUM_W'(my_q * my_q);
		end
		if (state_q == ST_VOTE_RD) begin
			addr_q <= vote_addr;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			clr_q    <= '0;
			i_q      <= '0;
			r_q      <= '0;
			nx_q     <= '0;
			ny_q     <= '0;
			bit_q    <= '0;
			search_q <= 1'b0;
			phase_q  <= '0;
			j_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						case (mode)
							hcgv_pkg::MODE_VOTE: begin
								if (count_in != '0) begin
									state_q <= ST_PREP;
								end
							end
							hcgv_pkg::MODE_READ: state_q <= ST_RD;
							hcgv_pkg::MODE_CLEAR: begin
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							default: ;
						endcase
					end
				end
				ST_PREP: begin
					i_q      <= '0;
					r_q      <= RAD_W'(min_radius_q);
					nx_q     <= '0;
					ny_q     <= '0;
					bit_q    <= 3'd6;
					search_q <= 1'b1;
					phase_q  <= '0;
					j_q      <= 1'b0;
					state_q  <= zero_q ? ST_VOTE_RD : ST_TEST;
				end
				ST_TEST: begin
					if (phase_q != 2'd2) begin
						phase_q <= phase_q + 2'd1;
					end else begin
						phase_q <= '0;
						if (pass_x && cand_x <= r_q) begin
							nx_q <= cand_x;
						end
						if (pass_y && cand_y <= r_q) begin
							ny_q <= cand_y;
						end
						if (search_q && bit_q != 3'd0) begin
							bit_q <= bit_q - 3'd1;
						end else begin
							j_q     <= 1'b0;
							state_q <= ST_VOTE_RD;
						end
					end
				end
				ST_VOTE_RD, ST_VOTE_WR: begin
					if (state_q == ST_VOTE_RD && in_bounds) begin
						state_q <= ST_VOTE_WR;
					end else if (!j_q) begin
						j_q     <= 1'b1;
						state_q <= ST_VOTE_RD;
					end else if (i_q + CNT_W'(1) == count_q) begin
						state_q <= ST_IDLE;
					end else begin
						i_q      <= i_q + CNT_W'(1);
						r_q      <= r_q + RAD_W'(1);
						search_q <= 1'b0;
						phase_q  <= '0;
						j_q      <= 1'b0;
						state_q  <= zero_q ? ST_VOTE_RD : ST_TEST;
					end
				end
				ST_RD:     state_q <= ST_RD_OUT;
				ST_RD_OUT: state_q <= ST_IDLE;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
